>>> rtl/prm_pkg.sv
package prm_pkg;

  // field widths
  localparam int GROUP_W = 6;
  localparam int RB_W = 7;
  localparam int CELL_ID_W = 9;
  localparam int NG_W = 4;
  localparam int CTRL_W = 9;
  localparam int FIRST_W = 8;
  localparam int SECOND_W = 9;
  localparam int TOTAL_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;

  // padded stream widths
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 40;

  // divider chain geometry
  localparam int REM_W = 18;
  localparam int QUOT_W = 11;
  localparam int A_STEPS = 11;
  localparam int A_SHIFT = A_STEPS - 1;
  localparam int B_STEPS = 7;
  localparam int B_SHIFT = B_STEPS - 1;

  // bandwidth and factor limits
  localparam logic [RB_W-1:0] RB_MIN = 7'd6;
  localparam logic [RB_W-1:0] RB_MAX = 7'd110;
  localparam logic [NG_W-1:0] NG_MAX = 4'd12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_BLOCKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_ID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NG_TIMES_SIX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_PREFIX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_REG_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_REG_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_REG_C = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_REG_D = 3'd7;

  // per-item data that rides along the chain untouched
  typedef struct packed {
    logic [GROUP_W-1:0] group_index;
    logic               group_valid;
    logic [TOTAL_W-1:0] group_total;
    logic [FIRST_W-1:0] reg_first;
  } side_t;

  // contents of one divider cell
  typedef struct packed {
    logic [REM_W-1:0]  divisor;
    logic [REM_W-1:0]  rem_a;
    logic [REM_W-1:0]  rem_b;
    logic [REM_W-1:0]  rem_c;
    logic [QUOT_W-1:0] quot;
    side_t             side;
  } lane_t;

endpackage

>>> rtl/prm_div_cell.sv
module prm_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  prm_pkg::lane_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output prm_pkg::lane_t out_data
);
  import prm_pkg::*;

  lane_t step;

  // one restoring step on three remainders against a shared divisor
  always_comb begin
    step = in_data;
    if (in_data.rem_a >= in_data.divisor) begin
      step.rem_a = in_data.rem_a - in_data.divisor;
    end
    if (in_data.rem_b >= in_data.divisor) begin
      step.rem_b = in_data.rem_b - in_data.divisor;
    end
    if (in_data.rem_c >= in_data.divisor) begin
      step.rem_c = in_data.rem_c - in_data.divisor;
    end
    step.quot = {in_data.quot[QUOT_W-2:0], in_data.rem_a >= in_data.divisor};
    step.divisor = in_data.divisor >> 1;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= step;
    end
  end

endmodule

>>> rtl/phich_reg_index_mapper.sv
// phich group to resource element group mapper
// s_* channel: one transfer per group query, s_tdata[5:0] = group_index.
// m_* channel: one transfer per query, same order, fields listed at the port.
// cfg_* port: write-only register file, to be written by the user only
// while no query is in flight (the block does not check this); a write
// takes effect for every query that is accepted after it. the query runs
// through a front stage, a chain of 11 divider cells that produce
// floor(cell_id*3N/(2N-4)) and the first-symbol index mod 2N-4, a fix-up
// stage (pcfich check, offsets), 7 divider cells for the mod 3N reductions
// and an output register. every stage has its own valid and ready, so
// bubbles are squeezed out and, while m_tready is high, a new query is
// taken each cycle: one query per clock. when m_tready is low the chain
// fills up stage by stage and s_tready drops only once all 21 stages hold
// a query. rst clears all valid bits and loads the register reset values
// (25 resource blocks, cell id 0, ng*6 = 6, normal prefix, pcfich regs 0).
module phich_reg_index_mapper (
  input  logic                                 clk,
  input  logic                                 rst,
  // group_index
  input  logic [prm_pkg::S_DATA_W-1:0]         s_tdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // reg_first, reg_second, reg_third, group_valid, group_total, zero pad
  output logic [prm_pkg::M_DATA_W-1:0]         m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_we,
  input  logic [prm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [prm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import prm_pkg::*;

  // configuration registers
  logic [RB_W-1:0]      resource_blocks;
  logic [CELL_ID_W-1:0] cell_id;
  logic [NG_W-1:0]      ng_times_six;
  logic                 extended_prefix;
  logic [CTRL_W-1:0]    control_reg_a;
  logic [CTRL_W-1:0]    control_reg_b;
  logic [CTRL_W-1:0]    control_reg_c;
  logic [CTRL_W-1:0]    control_reg_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      resource_blocks <= 7'd25;
      cell_id         <= '0;
      ng_times_six    <= 4'd6;
      extended_prefix <= 1'b0;
      control_reg_a   <= '0;
      control_reg_b   <= '0;
      control_reg_c   <= '0;
      control_reg_d   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESOURCE_BLOCKS: resource_blocks <= cfg_data[RB_W-1:0];
        CFG_CELL_ID:         cell_id <= cfg_data[CELL_ID_W-1:0];
        CFG_NG_TIMES_SIX:    ng_times_six <= cfg_data[NG_W-1:0];
        CFG_EXTENDED_PREFIX: extended_prefix <= cfg_data[0];
        CFG_CONTROL_REG_A:   control_reg_a <= cfg_data[CTRL_W-1:0];
        CFG_CONTROL_REG_B:   control_reg_b <= cfg_data[CTRL_W-1:0];
        CFG_CONTROL_REG_C:   control_reg_c <= cfg_data[CTRL_W-1:0];
        CFG_CONTROL_REG_D:   control_reg_d <= cfg_data[CTRL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // config-derived; the user keeps them stable while queries are in flight
  logic [RB_W-1:0]   nrb;
  logic [NG_W-1:0]   ng;
  logic [FIRST_W-1:0] n0;    // 2N-4, at most 216
  logic [SECOND_W-1:0] n1;   // 3N, at most 330
  logic [10:0]       grp_num;
  logic [6:0]        grp_div16;
  logic [11:0]       grp_recip;
  logic [4:0]        grp_half;
  logic [TOTAL_W-1:0] grp_total;

  always_comb begin
    nrb = resource_blocks;
    if (resource_blocks < RB_MIN) begin
      nrb = RB_MIN;
    end else if (resource_blocks > RB_MAX) begin
      nrb = RB_MAX;
    end
    ng = (ng_times_six > NG_MAX) ? NG_MAX : ng_times_six;
    n0 = {nrb, 1'b0} - 8'd4;
    n1 = {1'b0, nrb, 1'b0} + {2'b0, nrb};
    // ceil(ng*N/48) = floor((ng*N+47)/16/3), the /3 by multiply with 43/128
    grp_num = 11'(ng) * 11'(nrb) + 11'd47;
    grp_div16 = grp_num[10:4];
    grp_recip = {5'b0, grp_div16} * 12'd43;
    grp_half = grp_recip[11:7];
    grp_total = extended_prefix ? {grp_half, 1'b0} : {1'b0, grp_half};
  end

  // front stage: load the first divider lane
  logic  front_valid;
  lane_t front_data;
  lane_t front_next;
  logic  front_ready;
  logic [GROUP_W-1:0] group_in;

  assign group_in = s_tdata[GROUP_W-1:0];

  always_comb begin
    front_next = '0;
    front_next.divisor = REM_W'(n0) << A_SHIFT;
    front_next.rem_a = REM_W'(cell_id) * REM_W'(n1);
    front_next.rem_b = REM_W'(cell_id) + REM_W'(group_in);
    front_next.rem_c = REM_W'(cell_id) + REM_W'(group_in) + REM_W'(1);
    front_next.side.group_index = group_in;
    // valid below half the count (the count is doubled for extended prefix)
    front_next.side.group_valid = group_in < {1'b0, grp_total[TOTAL_W-1:1]};
    front_next.side.group_total = grp_total;
  end

  logic a_valid [0:A_STEPS];
  logic a_ready [0:A_STEPS];
  lane_t a_data [0:A_STEPS];

  assign front_ready = !front_valid || a_ready[0];
  assign s_tready = front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (front_ready) begin
      front_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && front_ready) begin
      front_data <= front_next;
    end
  end

  assign a_valid[0] = front_valid;
  assign a_data[0] = front_data;

  // first chain: quotient for the second/third symbol base, remainders mod n0
  for (genvar i = 0; i < A_STEPS; i++) begin : g_a_cell
    prm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (a_valid[i]),
      .in_ready  (a_ready[i]),
      .in_data   (a_data[i]),
      .out_valid (a_valid[i+1]),
      .out_ready (a_ready[i+1]),
      .out_data  (a_data[i+1])
    );
  end

  // fix-up stage: pcfich avoidance and offsets for the mod 3N lanes
  logic  fix_valid;
  lane_t fix_data;
  lane_t fix_next;
  logic  fix_ready;
  lane_t a_last;
  logic  pcfich_hit;
  logic [11:0] base_sum;

  assign a_last = a_data[A_STEPS];

  always_comb begin
    // a single bump to the next index, no second check
    pcfich_hit = (a_last.rem_b == REM_W'(control_reg_a)) ||
                 (a_last.rem_b == REM_W'(control_reg_b)) ||
                 (a_last.rem_b == REM_W'(control_reg_c)) ||
                 (a_last.rem_b == REM_W'(control_reg_d));
    base_sum = {1'b0, a_last.quot} + 12'(a_last.side.group_index) + 12'(nrb);
    fix_next = '0;
    fix_next.side = a_last.side;
    fix_next.side.reg_first = pcfich_hit ? a_last.rem_c[FIRST_W-1:0]
                                         : a_last.rem_b[FIRST_W-1:0];
    fix_next.divisor = REM_W'(n1) << B_SHIFT;
    fix_next.rem_a = REM_W'(base_sum);
    fix_next.rem_b = REM_W'(base_sum) + REM_W'(nrb);
  end

  logic b_valid [0:B_STEPS];
  logic b_ready [0:B_STEPS];
  lane_t b_data [0:B_STEPS];

  assign fix_ready = !fix_valid || b_ready[0];
  assign a_ready[A_STEPS] = fix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid <= 1'b0;
    end else if (fix_ready) begin
      fix_valid <= a_valid[A_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid[A_STEPS] && fix_ready) begin
      fix_data <= fix_next;
    end
  end

  assign b_valid[0] = fix_valid;
  assign b_data[0] = fix_data;

  // second chain: reduce both offsets mod n1
  for (genvar j = 0; j < B_STEPS; j++) begin : g_b_cell
    prm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (b_valid[j]),
      .in_ready  (b_ready[j]),
      .in_data   (b_data[j]),
      .out_valid (b_valid[j+1]),
      .out_ready (b_ready[j+1]),
      .out_data  (b_data[j+1])
    );
  end

  // output register, invalid groups report zero indices
  logic [M_DATA_W-1:0] out_next;
  logic                out_ready;
  lane_t               b_last;

  assign b_last = b_data[B_STEPS];

  always_comb begin
    out_next = '0;
    if (b_last.side.group_valid) begin
      out_next[FIRST_W-1:0] = b_last.side.reg_first;
      out_next[FIRST_W +: SECOND_W] = b_last.rem_a[SECOND_W-1:0];
      out_next[FIRST_W+SECOND_W +: SECOND_W] = b_last.rem_b[SECOND_W-1:0];
    end
    out_next[FIRST_W+2*SECOND_W] = b_last.side.group_valid;
    out_next[FIRST_W+2*SECOND_W+1 +: TOTAL_W] = b_last.side.group_total;
  end

  assign out_ready = !m_tvalid || m_tready;
  assign b_ready[B_STEPS] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= b_valid[B_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid[B_STEPS] && out_ready) begin
      m_tdata <= out_next;
    end
  end

endmodule
